// File: src/rdq_pkg.sv
// ============================================================================
// rdq_pkg: shared constants for the rotating deque
// Operation codes, result kinds and the fixed field widths of the stream beats.
// ============================================================================
`default_nettype none

package rdq_pkg;

   // Fixed field widths
   localparam int DATA_W = 32;
   localparam int OP_W   = 3;
   localparam int KIND_W = 2;

   // Operation codes carried on the request tuser
   localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
   localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
   localparam logic [OP_W-1:0] OP_ROT_LEFT   = 3'd2;
   localparam logic [OP_W-1:0] OP_ROT_RIGHT  = 3'd3;
   localparam logic [OP_W-1:0] OP_DUMP       = 3'd4;

   // Result kinds carried on the response tuser
   localparam logic [KIND_W-1:0] KIND_DONE  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_FULL  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd2;
   localparam logic [KIND_W-1:0] KIND_ENTRY = 2'd3;

   typedef logic [DATA_W-1:0] data_type;

endpackage

`default_nettype wire

// File: src/rdq_ram.sv
// ============================================================================
// rdq_ram: generic single-clock RAM
// One write port and one read port; read data is registered.
// ============================================================================
`default_nettype none

module rdq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read; read data holds until the next read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: src/rotating_deque.sv
// ============================================================================
// rotating_deque: ring-buffer deque with push, rotate and dump
// Holds up to DEPTH signed 32-bit values in one RAM with front pointer and count.
// ============================================================================
// One request beat at a time is processed; the request side takes a beat
// whenever the sequencer is idle, even while a response beat is still waiting
// in the output register. A push is a RAM write, then a response load; a
// rotation is a RAM read, a write back and a response load, since it moves one
// entry through the single registered read port of the RAM. A dump reads each
// entry in turn (RAM read, then response load) and gives occupancy response
// beats, the final one with tlast set; an empty dump or a rotation on an empty
// deque gives a single "empty" beat. A push into a full deque is dropped and
// answered with a "full" beat. Response stalls hold the sequencer waiting.
`default_nettype none

module rotating_deque #(
   parameter int DEPTH = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,  // [31:0] value
   input  wire logic [2:0]  req_tuser,  // [2:0] opcode
   // response channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [31:0] rsp_tdata,  // [31:0] item
   output logic      [1:0]  rsp_tuser,  // [1:0] kind
   output logic             rsp_tlast   // last
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);
   localparam logic [CNT_W:0]   DEPTH_SUM = (CNT_W + 1)'(DEPTH);

   // sequencer states
   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_ROT     = 3'd1;
   localparam logic [2:0] S_EMIT    = 3'd2;
   localparam logic [2:0] S_DUMP_RD = 3'd3;
   localparam logic [2:0] S_DUMP_WT = 3'd4;

   // (base + offset) mod DEPTH with one compare and subtract
   function automatic logic [IDX_W-1:0] ring_pos(input logic [IDX_W-1:0] base,
                                                 input logic [CNT_W-1:0] off);
      logic [CNT_W:0] sum;
      sum = {{(CNT_W + 1 - IDX_W){1'b0}}, base} + {1'b0, off};
      if (sum >= DEPTH_SUM) begin
         sum = sum - DEPTH_SUM;
      end
      return sum[IDX_W-1:0];
   endfunction

   logic [2:0]                  state_ff, state_in;
   logic [IDX_W-1:0]            front_ff, front_in;
   logic [CNT_W-1:0]            occ_ff, occ_in;
   logic [CNT_W-1:0]            idx_ff, idx_in;
   logic [IDX_W-1:0]            dst_ff, dst_in;
   logic [rdq_pkg::KIND_W-1:0]  pend_ff, pend_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [rdq_pkg::KIND_W-1:0]  rsp_kind_ff, rsp_kind_in;
   rdq_pkg::data_type           rsp_item_ff, rsp_item_in;
   logic                        rsp_last_ff, rsp_last_in;

   logic                        wr_en, rd_en;
   logic [IDX_W-1:0]            wr_addr, rd_addr;
   rdq_pkg::data_type           wr_data, rd_data;

   logic                        accept, out_free, load;
   logic                        occ_full, occ_empty, dump_last;
   logic [IDX_W-1:0]            pos_prev, pos_next, pos_back, pos_last, pos_dump;

   rdq_ram #(
      .WIDTH (rdq_pkg::DATA_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Handshakes and ring positions
   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign occ_full   = (occ_ff == DEPTH_CNT);
   assign occ_empty  = (occ_ff == '0);
   assign dump_last  = ((idx_ff + CNT_W'(1)) == occ_ff);
   assign pos_prev   = ring_pos(front_ff, DEPTH_CNT - CNT_W'(1));
   assign pos_next   = ring_pos(front_ff, CNT_W'(1));
   assign pos_back   = ring_pos(front_ff, occ_ff);
   assign pos_last   = ring_pos(front_ff, occ_ff - CNT_W'(1));
   assign pos_dump   = ring_pos(front_ff, idx_ff);

   // Sequencer: decode, read, write back, emit
   always_comb begin
      state_in    = state_ff;
      front_in    = front_ff;
      occ_in      = occ_ff;
      idx_in      = idx_ff;
      dst_in      = dst_ff;
      pend_in     = pend_ff;
      wr_en       = 1'b0;
      wr_addr     = '0;
      wr_data     = '0;
      rd_en       = 1'b0;
      rd_addr     = '0;
      load        = 1'b0;
      rsp_kind_in = rsp_kind_ff;
      rsp_item_in = rsp_item_ff;
      rsp_last_in = rsp_last_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_EMIT;
               pend_in  = rdq_pkg::KIND_DONE;
               case (req_tuser)
                  rdq_pkg::OP_PUSH_FRONT: begin
                     if (occ_full) begin
                        pend_in = rdq_pkg::KIND_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        wr_addr  = pos_prev;
                        wr_data  = req_tdata;
                        front_in = pos_prev;
                        occ_in   = occ_ff + CNT_W'(1);
                     end
                  end
                  rdq_pkg::OP_PUSH_BACK: begin
                     if (occ_full) begin
                        pend_in = rdq_pkg::KIND_FULL;
                     end else begin
                        wr_en   = 1'b1;
                        wr_addr = pos_back;
                        wr_data = req_tdata;
                        occ_in  = occ_ff + CNT_W'(1);
                     end
                  end
                  rdq_pkg::OP_ROT_LEFT: begin
                     if (occ_empty) begin
                        pend_in = rdq_pkg::KIND_EMPTY;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = front_ff;
                        dst_in   = pos_back;
                        front_in = pos_next;
                        state_in = S_ROT;
                     end
                  end
                  rdq_pkg::OP_ROT_RIGHT: begin
                     if (occ_empty) begin
                        pend_in = rdq_pkg::KIND_EMPTY;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = pos_last;
                        dst_in   = pos_prev;
                        front_in = pos_prev;
                        state_in = S_ROT;
                     end
                  end
                  rdq_pkg::OP_DUMP: begin
                     if (occ_empty) begin
                        pend_in = rdq_pkg::KIND_EMPTY;
                     end else begin
                        idx_in   = '0;
                        state_in = S_DUMP_RD;
                     end
                  end
                  default: begin
                     pend_in = rdq_pkg::KIND_DONE;
                  end
               endcase
            end
         end
         S_ROT: begin
            // write the moved entry back at its new end
            wr_en    = 1'b1;
            wr_addr  = dst_ff;
            wr_data  = rd_data;
            pend_in  = rdq_pkg::KIND_DONE;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (out_free) begin
               load        = 1'b1;
               rsp_kind_in = pend_ff;
               rsp_item_in = '0;
               rsp_last_in = 1'b1;
               state_in    = S_IDLE;
            end
         end
         S_DUMP_RD: begin
            rd_en    = 1'b1;
            rd_addr  = pos_dump;
            state_in = S_DUMP_WT;
         end
         S_DUMP_WT: begin
            if (out_free) begin
               load        = 1'b1;
               rsp_kind_in = rdq_pkg::KIND_ENTRY;
               rsp_item_in = rd_data;
               rsp_last_in = dump_last;
               if (dump_last) begin
                  state_in = S_IDLE;
               end else begin
                  idx_in   = idx_ff + CNT_W'(1);
                  state_in = S_DUMP_RD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Output register: load when free, drop the beat once taken
   always_comb begin
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         front_ff     <= '0;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         front_ff     <= front_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload and working registers
   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      dst_ff      <= dst_in;
      pend_ff     <= pend_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_item_ff <= rsp_item_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_item_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

   // Occupancy never passes the store size
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= DEPTH_CNT)
      else $error("occupancy above DEPTH");

   // Every beat other than a dumped entry closes its request
   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != rdq_pkg::KIND_ENTRY) |-> rsp_tlast)
      else $error("single-beat response without tlast");

   // A push that fits grows the count by one
   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      accept && !occ_full &&
      (req_tuser == rdq_pkg::OP_PUSH_FRONT || req_tuser == rdq_pkg::OP_PUSH_BACK)
      |=> occ_ff == CNT_W'($past(occ_ff) + CNT_W'(1)))
      else $error("push did not advance occupancy");

   // The final dumped entry returns the sequencer to idle
   a_dump_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DUMP_WT) && out_free && dump_last |=> state_ff == S_IDLE)
      else $error("dump did not finish");

endmodule

`default_nettype wire

// File: test/rotating_deque_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// rotating_deque_tb: self-checking bench for the rotating deque
// Drives push, rotate, dump and unused operations over the request stream and
// checks every response beat against a shadow deque kept in the bench. A short
// table of directed operations runs first, then random traffic with random
// gaps and stalls on both streams and one long response hold-off.
// ============================================================================

module rotating_deque_tb;

   localparam int DEPTH       = 32;
   localparam int PTR_W       = $clog2(DEPTH);
   localparam int NUM_RANDOM  = 330;
   localparam int HOLD_CYCLES = 300;
   localparam int QUIET_LIMIT = 3000;
   localparam int TAIL_CYCLES = 40;
   localparam int MAX_REPORTS = 10;

   // Opcodes the block ignores
   localparam logic [rdq_pkg::OP_W-1:0] OP_RSVD5 = 3'd5;
   localparam logic [rdq_pkg::OP_W-1:0] OP_RSVD6 = 3'd6;
   localparam logic [rdq_pkg::OP_W-1:0] OP_RSVD7 = 3'd7;

   typedef struct {
      logic [rdq_pkg::KIND_W-1:0] kind;
      logic [rdq_pkg::DATA_W-1:0] item;
      logic                       last;
   } rsp_beat_type;

   typedef struct {
      logic [rdq_pkg::OP_W-1:0]   op;
      logic [rdq_pkg::DATA_W-1:0] val;
      bit                         typed;
      logic [rdq_pkg::KIND_W-1:0] kind;
   } stim_row_type;

   localparam int DIR_ROWS = 21;

   // Directed operations; typed rows carry their single expected kind
   stim_row_type dir_rows [DIR_ROWS] = '{
      '{rdq_pkg::OP_ROT_LEFT,   32'h0000_0000, 1'b1, rdq_pkg::KIND_EMPTY},
      '{rdq_pkg::OP_ROT_RIGHT,  32'hFFFF_FFFF, 1'b1, rdq_pkg::KIND_EMPTY},
      '{rdq_pkg::OP_DUMP,       32'h0000_0000, 1'b1, rdq_pkg::KIND_EMPTY},
      '{rdq_pkg::OP_PUSH_BACK,  32'h7FFF_FFFF, 1'b1, rdq_pkg::KIND_DONE},
      '{rdq_pkg::OP_PUSH_FRONT, 32'h8000_0000, 1'b1, rdq_pkg::KIND_DONE},
      '{rdq_pkg::OP_PUSH_BACK,  32'h0000_0000, 1'b1, rdq_pkg::KIND_DONE},
      '{rdq_pkg::OP_PUSH_FRONT, 32'hFFFF_FFFF, 1'b1, rdq_pkg::KIND_DONE},
      '{rdq_pkg::OP_DUMP,       32'h0000_0000, 1'b0, rdq_pkg::KIND_DONE},
      '{rdq_pkg::OP_ROT_LEFT,   32'hFFFF_FFFF, 1'b0, rdq_pkg::KIND_DONE},
      '{rdq_pkg::OP_DUMP,       32'h0000_0000, 1'b0, rdq_pkg::KIND_DONE},
      '{rdq_pkg::OP_ROT_RIGHT,  32'h0000_0000, 1'b0, rdq_pkg::KIND_DONE},
      '{rdq_pkg::OP_ROT_RIGHT,  32'hA5A5_A5A5, 1'b0, rdq_pkg::KIND_DONE},
      '{rdq_pkg::OP_DUMP,       32'h0000_0000, 1'b0, rdq_pkg::KIND_DONE},
      '{OP_RSVD5,               32'hAAAA_AAAA, 1'b1, rdq_pkg::KIND_DONE},
      '{OP_RSVD6,               32'h5555_5555, 1'b1, rdq_pkg::KIND_DONE},
      '{OP_RSVD7,               32'hFFFF_FFFF, 1'b1, rdq_pkg::KIND_DONE},
      '{rdq_pkg::OP_PUSH_BACK,  32'h0000_0001, 1'b0, rdq_pkg::KIND_DONE},
      '{rdq_pkg::OP_ROT_LEFT,   32'h1234_5678, 1'b0, rdq_pkg::KIND_DONE},
      '{rdq_pkg::OP_DUMP,       32'h0000_0000, 1'b0, rdq_pkg::KIND_DONE},
      '{rdq_pkg::OP_PUSH_FRONT, 32'h5A5A_5A5A, 1'b0, rdq_pkg::KIND_DONE},
      '{rdq_pkg::OP_DUMP,       32'h0000_0000, 1'b0, rdq_pkg::KIND_DONE}
   };

   logic              clock = 1'b0;
   logic              reset;
   logic              req_tvalid;
   logic              req_tready;
   logic [31:0]       req_tdata;   // [31:0] value
   logic [2:0]        req_tuser;   // [2:0] opcode
   logic              rsp_tvalid;
   logic              rsp_tready;
   logic [31:0]       rsp_tdata;   // [31:0] item
   logic [1:0]        rsp_tuser;   // [1:0] kind
   logic              rsp_tlast;

   // Shadow deque
   logic [rdq_pkg::DATA_W-1:0] shadow_mem [DEPTH];
   logic [PTR_W-1:0]           shadow_front;
   logic [PTR_W:0]             shadow_count;

   rsp_beat_type      op_beats [$];
   rsp_beat_type      rsp_due [$];
   rsp_beat_type      want;
   int                miss_count;
   int                quiet_cycles;
   bit                calm;
   bit                hold_pending;

   rotating_deque #(
      .DEPTH (DEPTH)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   function automatic logic [PTR_W-1:0] ring_slot(input int offset);
      return PTR_W'((int'(shadow_front) + offset) % DEPTH);
   endfunction

   function automatic bit idle_roll();
      return !calm && ($urandom_range(99) < 15);
   endfunction

   task automatic emit(input logic [rdq_pkg::KIND_W-1:0] kind,
                       input logic [rdq_pkg::DATA_W-1:0] item,
                       input logic last);
      rsp_beat_type b;
      b.kind = kind;
      b.item = item;
      b.last = last;
      op_beats.push_back(b);
   endtask

   // Apply one operation to the shadow deque and collect its response beats
   task automatic apply_deque_op(input logic [rdq_pkg::OP_W-1:0] op,
                                 input logic [rdq_pkg::DATA_W-1:0] val);
      logic [rdq_pkg::DATA_W-1:0] moved;
      int                         i;
      op_beats.delete();
      case (op)
         rdq_pkg::OP_PUSH_FRONT, rdq_pkg::OP_PUSH_BACK: begin
            if (shadow_count >= DEPTH) begin
               emit(rdq_pkg::KIND_FULL, '0, 1'b1);
            end else begin
               if (op == rdq_pkg::OP_PUSH_FRONT) begin
                  shadow_front = ring_slot(DEPTH - 1);
                  shadow_mem[shadow_front] = val;
               end else begin
                  shadow_mem[ring_slot(int'(shadow_count))] = val;
               end
               shadow_count = shadow_count + (PTR_W + 1)'(1);
               emit(rdq_pkg::KIND_DONE, '0, 1'b1);
            end
         end
         rdq_pkg::OP_ROT_LEFT: begin
            if (shadow_count == 0) begin
               emit(rdq_pkg::KIND_EMPTY, '0, 1'b1);
            end else begin
               shadow_mem[ring_slot(int'(shadow_count))] = shadow_mem[shadow_front];
               shadow_front = ring_slot(1);
               emit(rdq_pkg::KIND_DONE, '0, 1'b1);
            end
         end
         rdq_pkg::OP_ROT_RIGHT: begin
            if (shadow_count == 0) begin
               emit(rdq_pkg::KIND_EMPTY, '0, 1'b1);
            end else begin
               moved = shadow_mem[ring_slot(int'(shadow_count) - 1)];
               shadow_front = ring_slot(DEPTH - 1);
               shadow_mem[shadow_front] = moved;
               emit(rdq_pkg::KIND_DONE, '0, 1'b1);
            end
         end
         rdq_pkg::OP_DUMP: begin
            if (shadow_count == 0) begin
               emit(rdq_pkg::KIND_EMPTY, '0, 1'b1);
            end else begin
               for (i = 0; i < int'(shadow_count); i++) begin
                  emit(rdq_pkg::KIND_ENTRY, shadow_mem[ring_slot(i)],
                       i == int'(shadow_count) - 1);
               end
            end
         end
         default: begin
            emit(rdq_pkg::KIND_DONE, '0, 1'b1);
         end
      endcase
   endtask

   // Offer one request beat, starting at a falling edge; return at a falling edge
   task automatic offer(input logic [rdq_pkg::OP_W-1:0] op,
                        input logic [rdq_pkg::DATA_W-1:0] val,
                        input bit typed, input logic [rdq_pkg::KIND_W-1:0] kind);
      rsp_beat_type b;
      while (idle_roll()) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= val;
      do @(posedge clock); while (!req_tready);
      apply_deque_op(op, val);
      if (typed) begin
         b.kind = kind;
         b.item = '0;
         b.last = 1'b1;
         rsp_due.push_back(b);
      end else begin
         foreach (op_beats[k]) rsp_due.push_back(op_beats[k]);
      end
      @(negedge clock);
   endtask

   task automatic report_miss(input string what);
      miss_count++;
      if (miss_count <= MAX_REPORTS) begin
         $display("mismatch (%s): expected kind %0d item %h last %0b,",
                  what, want.kind, want.item, want.last);
         $display("   got kind %0d item %h last %0b", rsp_tuser, rsp_tdata, rsp_tlast);
      end
   endtask

   // Check each response beat against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (rsp_due.size() == 0) begin
            want = '{'0, '0, 1'b0};
            report_miss("no beat expected");
         end else begin
            want = rsp_due.pop_front();
            if (rsp_tuser !== want.kind || rsp_tdata !== want.item ||
                rsp_tlast !== want.last) begin
               report_miss("field");
            end
         end
      end
   end

   // Watchdog: end the run when neither stream moves for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Response side: random stalls, one long hold-off on request
   initial begin
      bit hold_taken;
      hold_taken = 1'b0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_pending && !hold_taken) begin
            hold_taken = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         rsp_tready <= !idle_roll();
      end
   end

   // Reset, stimulus and end of run
   initial begin
      int                         n;
      int                         roll;
      logic [rdq_pkg::OP_W-1:0]   op;
      logic [rdq_pkg::DATA_W-1:0] val;

      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tuser    = '0;
      calm         = 1'b0;
      hold_pending = 1'b0;
      shadow_front = '0;
      shadow_count = '0;
      foreach (shadow_mem[k]) shadow_mem[k] = '0;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed table
      for (n = 0; n < DIR_ROWS; n++) begin
         offer(dir_rows[n].op, dir_rows[n].val, dir_rows[n].typed, dir_rows[n].kind);
      end

      // Random traffic; pushes fill the deque and then overflow it
      for (n = 0; n < NUM_RANDOM; n++) begin
         if (n == 120) hold_pending = 1'b1;
         calm = (n >= 200 && n < 280);
         roll = $urandom_range(99);
         if (roll < 14)      op = rdq_pkg::OP_PUSH_FRONT;
         else if (roll < 28) op = rdq_pkg::OP_PUSH_BACK;
         else if (roll < 54) op = rdq_pkg::OP_ROT_LEFT;
         else if (roll < 80) op = rdq_pkg::OP_ROT_RIGHT;
         else if (roll < 87) op = rdq_pkg::OP_DUMP;
         else if (roll < 97) op = rdq_pkg::OP_ROT_LEFT;
         else                op = rdq_pkg::OP_W'($urandom_range(7, 5));
         val = $urandom;
         if ($urandom_range(7) == 0) val = $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
         offer(op, val, 1'b0, rdq_pkg::KIND_DONE);
      end
      calm = 1'b0;
      req_tvalid <= 1'b0;

      // Drain, then let any stray beats show up
      while (rsp_due.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (miss_count == 0 && rsp_due.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
